FILE: rtl/vp8hq_pkg.sv
// Package for the VP8 header quantizer extractor.
// Syntax phase codes, microcode word type and the control ROM; no dependencies.
package vp8hq_pkg;

  localparam int SEGMENT_COUNT      = 4;
  localparam int SEGMENT_TREE_PROBS = 3;
  localparam int REF_DELTA_COUNT    = 4;
  localparam int MODE_DELTA_COUNT   = 4;
  localparam int COUNT_BITS         = 20;
  localparam int PLEN_BITS          = 19;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [4:0] PH_CS         = 5'd0;
  localparam logic [4:0] PH_CLAMP      = 5'd1;
  localparam logic [4:0] PH_SEG_EN     = 5'd2;
  localparam logic [4:0] PH_SEG_MAP    = 5'd3;
  localparam logic [4:0] PH_SEG_DATA   = 5'd4;
  localparam logic [4:0] PH_SEG_MODE   = 5'd5;
  localparam logic [4:0] PH_SEG_Q      = 5'd6;
  localparam logic [4:0] PH_SEG_LF     = 5'd7;
  localparam logic [4:0] PH_SEG_PROB   = 5'd8;
  localparam logic [4:0] PH_FILT_TYPE  = 5'd9;
  localparam logic [4:0] PH_FILT_LEVEL = 5'd10;
  localparam logic [4:0] PH_SHARP      = 5'd11;
  localparam logic [4:0] PH_ADJ_EN     = 5'd12;
  localparam logic [4:0] PH_ADJ_UPD    = 5'd13;
  localparam logic [4:0] PH_REF        = 5'd14;
  localparam logic [4:0] PH_MODE       = 5'd15;
  localparam logic [4:0] PH_NPART      = 5'd16;
  localparam logic [4:0] PH_QP         = 5'd17;
  localparam logic [4:0] PH_DONE       = 5'd18;

  // bit-driven jump kinds
  localparam logic [1:0] JK_ALWAYS = 2'd0;  // go to jmp0
  localparam logic [1:0] JK_BIT    = 2'd1;  // bit ? jmp1 : jmp0
  localparam logic [1:0] JK_LOOP   = 2'd2;  // bit starts literal, else advance loop
  localparam logic [1:0] JK_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] jmp0;
    logic [4:0] jmp1;
    logic [3:0] lit;    // literal length on entry or per loop element
    logic [3:0] count;  // loop count
    logic [4:0] done;   // phase after loop or literal completes
    logic       set_map;
    logic       map_sel; // after-segment-data choice on exit
  } uword_t;

  function automatic uword_t rom(input logic [4:0] ph);
    uword_t w;
    w = '{JK_NONE, PH_DONE, PH_DONE, 4'd0, 4'd0, PH_DONE, 1'b0, 1'b0};
    unique case (ph)
      PH_CS:         w = '{JK_ALWAYS, PH_CLAMP, PH_CLAMP, 4'd0, 4'd0, PH_DONE, 1'b0, 1'b0};
      PH_CLAMP:      w = '{JK_ALWAYS, PH_SEG_EN, PH_SEG_EN, 4'd0, 4'd0, PH_DONE, 1'b0, 1'b0};
      PH_SEG_EN:     w = '{JK_BIT, PH_FILT_TYPE, PH_SEG_MAP, 4'd0, 4'd0, PH_DONE, 1'b0, 1'b0};
      PH_SEG_MAP:    w = '{JK_ALWAYS, PH_SEG_DATA, PH_SEG_DATA, 4'd0, 4'd0, PH_DONE,
                           1'b1, 1'b0};
      PH_SEG_DATA:   w = '{JK_BIT, PH_FILT_TYPE, PH_SEG_MODE, 4'd0, 4'd0, PH_DONE,
                           1'b0, 1'b1};
      PH_SEG_MODE:   w = '{JK_ALWAYS, PH_SEG_Q, PH_SEG_Q, 4'd0, 4'd0, PH_DONE, 1'b0, 1'b0};
      PH_SEG_Q:      w = '{JK_LOOP, PH_DONE, PH_DONE, 4'd8, 4'(SEGMENT_COUNT), PH_SEG_LF,
                           1'b0, 1'b0};
      PH_SEG_LF:     w = '{JK_LOOP, PH_DONE, PH_DONE, 4'd7, 4'(SEGMENT_COUNT),
                           PH_FILT_TYPE, 1'b0, 1'b1};
      PH_SEG_PROB:   w = '{JK_LOOP, PH_DONE, PH_DONE, 4'd8, 4'(SEGMENT_TREE_PROBS),
                           PH_FILT_TYPE, 1'b0, 1'b0};
      PH_FILT_TYPE:  w = '{JK_ALWAYS, PH_FILT_LEVEL, PH_FILT_LEVEL, 4'd0, 4'd0, PH_DONE,
                           1'b0, 1'b0};
      PH_FILT_LEVEL: w = '{JK_NONE, PH_DONE, PH_DONE, 4'd6, 4'd0, PH_SHARP, 1'b0, 1'b0};
      PH_SHARP:      w = '{JK_NONE, PH_DONE, PH_DONE, 4'd3, 4'd0, PH_ADJ_EN, 1'b0, 1'b0};
      PH_ADJ_EN:     w = '{JK_BIT, PH_NPART, PH_ADJ_UPD, 4'd0, 4'd0, PH_DONE, 1'b0, 1'b0};
      PH_ADJ_UPD:    w = '{JK_BIT, PH_NPART, PH_REF, 4'd0, 4'd0, PH_DONE, 1'b0, 1'b0};
      PH_REF:        w = '{JK_LOOP, PH_DONE, PH_DONE, 4'd7, 4'(REF_DELTA_COUNT), PH_MODE,
                           1'b0, 1'b0};
      PH_MODE:       w = '{JK_LOOP, PH_DONE, PH_DONE, 4'd7, 4'(MODE_DELTA_COUNT), PH_NPART,
                           1'b0, 1'b0};
      PH_NPART:      w = '{JK_NONE, PH_DONE, PH_DONE, 4'd2, 4'd0, PH_QP, 1'b0, 1'b0};
      PH_QP:         w = '{JK_NONE, PH_DONE, PH_DONE, 4'd7, 4'd0, PH_DONE, 1'b0, 1'b0};
      default:       w = '{JK_NONE, PH_DONE, PH_DONE, 4'd0, 4'd0, PH_DONE, 1'b0, 1'b0};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/vp8_header_qp_extractor.sv
// VP8 frame header quantizer extractor, top level.
// Byte intake, frame tag, boolean decoder; uses vp8hq_pkg and vp8hq_seq.
//
// Usage: frame bytes enter on in_data_byte/in_last_byte with in_valid/in_ready.
// On the item marked last, one result (out_qp, out_status) is offered on
// out_valid/out_ready; other items give no result.
// Items are taken one per cycle while the decoder is idle. From the second
// partition byte on, a byte runs the shared decoder loop, which decodes
// bools and normalizes one shift at a time until eight shifts have used up
// the byte; no item is taken until the loop stops. Once the partition is
// used up the decoder keeps shifting in zeros until the quantizer is read.
// The result appears in the cycle after the last item is accepted. It sits
// in an output register; while the receiver stalls, the block still takes
// and decodes the next frame's bytes, and holds off only a new last item.
// Reset clears all frame state; the block is then ready at once.
module vp8_header_qp_extractor
  import vp8hq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_qp,
  output logic [1:0] out_status
);

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [23:0]           tag_r, tag_nxt;
  logic [COUNT_BITS-1:0] used_r, used_nxt;
  logic [7:0]            rng_r, rng_nxt;
  logic [15:0]           val_r, val_nxt;
  logic [3:0]            bc_r, bc_nxt;
  logic                  key_r, key_nxt;
  logic                  run_r, run_nxt;
  logic                  ov_r, ov_nxt;
  logic [6:0]            oqp_r, oqp_nxt;
  logic [1:0]            ost_r, ost_nxt;

  logic                  acc, start, clear, bit_vld, bit_val, qp_done;
  logic [6:0]            qp;
  logic [PLEN_BITS-1:0]  plen;
  logic [COUNT_BITS-1:0] hd, off;
  logic [COUNT_BITS:0]   need;
  logic [7:0]            split;

  assign plen  = tag_r[23:5];
  assign hd    = key_r ? COUNT_BITS'(10) : COUNT_BITS'(3);
  assign off   = cnt_r - hd;
  assign split = 8'd1 + 8'((rng_r - 8'd1) >> 1);
  assign need  = {1'b0, hd} + (COUNT_BITS+1)'(plen);

  assign in_ready = !run_r && !(in_last_byte && ov_r);
  assign acc      = in_valid && in_ready;

  always_comb begin
    cnt_nxt  = cnt_r;
    tag_nxt  = tag_r;
    used_nxt = used_r;
    rng_nxt  = rng_r;
    val_nxt  = val_r;
    bc_nxt   = bc_r;
    key_nxt  = key_r;
    run_nxt  = run_r;
    ov_nxt   = ov_r && !out_ready;
    oqp_nxt  = oqp_r;
    ost_nxt  = ost_r;
    start    = 1'b0;
    clear    = 1'b0;
    bit_vld  = 1'b0;
    bit_val  = 1'b0;

    if (run_r) begin
      // one decoder step per cycle
      if (bc_r >= 4'd8 && COUNT_BITS'(plen) > used_r) begin
        run_nxt = 1'b0;
      end else if (rng_r < 8'd128) begin
        val_nxt = {val_r[14:0], 1'b0};
        rng_nxt = {rng_r[6:0], 1'b0};
        bc_nxt  = (bc_r >= 4'd8) ? 4'd1 : bc_r + 4'd1;
      end else if (qp_done) begin
        run_nxt = 1'b0;
        if (bc_r >= 4'd8) bc_nxt = '0;
      end else begin
        if (bc_r >= 4'd8) bc_nxt = '0;
        bit_vld = 1'b1;
        if (val_r >= {split, 8'd0}) begin
          bit_val = 1'b1;
          rng_nxt = rng_r - split;
          val_nxt = val_r - {split, 8'd0};
        end else begin
          rng_nxt = split;
        end
      end
    end else if (acc) begin
      if (cnt_r != COUNT_MAX) begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r < COUNT_BITS'(3)) begin
          unique case (cnt_r[1:0])
            2'd0:    tag_nxt[7:0]   = in_data_byte;
            2'd1:    tag_nxt[15:8]  = in_data_byte;
            default: begin
              tag_nxt[23:16] = in_data_byte;
              key_nxt        = !tag_r[0];
            end
          endcase
        end else if (cnt_r >= hd && plen >= PLEN_BITS'(2) && off < COUNT_BITS'(plen)) begin
          if (used_r < COUNT_BITS'(2)) begin
            val_nxt  = {val_r[7:0], in_data_byte};
            used_nxt = used_r + 1'b1;
            if (used_r == COUNT_BITS'(1)) begin
              start   = 1'b1;
              run_nxt = 1'b1;
            end
          end else if (bc_r >= 4'd8) begin
            val_nxt  = {val_r[15:8], in_data_byte};
            bc_nxt   = '0;
            used_nxt = used_r + 1'b1;
            run_nxt  = 1'b1;
          end
        end
      end
      if (in_last_byte) begin
        clear   = 1'b1;
        run_nxt = 1'b0;
        ov_nxt  = 1'b1;
        oqp_nxt = '0;
        if (cnt_nxt < COUNT_BITS'(3)) begin
          ost_nxt = 2'd1;
        end else if ({1'b0, (key_nxt ? COUNT_BITS'(10) : COUNT_BITS'(3))} +
                     (COUNT_BITS+1)'(tag_nxt[23:5]) > {1'b0, cnt_nxt}) begin
          ost_nxt = 2'd2;
        end else if (!qp_done || used_nxt >= COUNT_BITS'(tag_nxt[23:5])) begin
          ost_nxt = 2'd3;
        end else begin
          ost_nxt = 2'd0;
          oqp_nxt = qp;
        end
        cnt_nxt  = '0;
        tag_nxt  = '0;
        used_nxt = '0;
        rng_nxt  = 8'd255;
        val_nxt  = '0;
        bc_nxt   = '0;
        key_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      tag_r  <= '0;
      used_r <= '0;
      rng_r  <= 8'd255;
      val_r  <= '0;
      bc_r   <= '0;
      key_r  <= 1'b0;
      run_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      tag_r  <= tag_nxt;
      used_r <= used_nxt;
      rng_r  <= rng_nxt;
      val_r  <= val_nxt;
      bc_r   <= bc_nxt;
      key_r  <= key_nxt;
      run_r  <= run_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oqp_r <= oqp_nxt;
    ost_r <= ost_nxt;
  end

  vp8hq_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (clear),
    .start   (start),
    .key     (key_r),
    .bit_vld (bit_vld),
    .bit_val (bit_val),
    .qp_done (qp_done),
    .qp      (qp)
  );

  assign out_valid  = ov_r;
  assign out_qp     = oqp_r;
  assign out_status = ost_r;

  a_no_take_while_run: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> !in_ready) else $error("item taken during decode");
  a_range_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r && !bit_vld) |-> (rng_r != 8'd0)) else $error("decoder range collapsed");
  a_status_qp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != 2'd0) |-> (out_qp == 7'd0)) else $error("qp on error");
  a_need_used: assert property (@(posedge clk) disable iff (!rst_n)
    (need != '0) |-> (used_r <= COUNT_BITS'(plen) || plen < PLEN_BITS'(2)))
    else $error("decoder overran partition");

endmodule

FILE: rtl/vp8hq_seq.sv
// Microcoded syntax sequencer: consumes decoded bools, walks the header syntax.
// Depends on vp8hq_pkg (phase codes and control ROM).
module vp8hq_seq
  import vp8hq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       clear,     // frame end
  input  logic       start,     // partition primed
  input  logic       key,
  input  logic       bit_vld,
  input  logic       bit_val,
  output logic       qp_done,
  output logic [6:0] qp
);

  logic [4:0] step_r, step_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [3:0] left_r, left_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic       map_r, map_nxt;
  logic [7:0] cqp_r, cqp_nxt;
  uword_t     uw;

  function automatic logic [4:0] exit_ph(input uword_t w, input logic m);
    logic [4:0] r;
    r = w.done;
    if (w.map_sel && m) r = PH_SEG_PROB;
    return r;
  endfunction

  // loop phases start on a flag bool, not inside a literal
  function automatic logic [3:0] entry_lit(input logic [4:0] ph);
    uword_t e;
    e = rom(ph);
    return (e.kind == JK_LOOP) ? 4'd0 : e.lit;
  endfunction

  always_comb begin
    uw       = rom(step_r);
    step_nxt = step_r;
    idx_nxt  = idx_r;
    left_nxt = left_r;
    acc_nxt  = acc_r;
    map_nxt  = map_r;
    cqp_nxt  = cqp_r;
    if (start) begin
      step_nxt = key ? PH_CS : PH_SEG_EN;
      idx_nxt  = '0;
      acc_nxt  = '0;
      left_nxt = entry_lit(key ? PH_CS : PH_SEG_EN);
    end else if (bit_vld) begin
      if (left_r != 4'd0) begin
        acc_nxt  = {acc_r[6:0], bit_val};
        left_nxt = left_r - 4'd1;
        if (left_r == 4'd1) begin
          if (uw.count != 4'd0) begin
            idx_nxt = idx_r + 4'd1;
            if (idx_nxt >= uw.count) begin
              step_nxt = exit_ph(uw, map_r);
              idx_nxt  = '0;
              acc_nxt  = '0;
              left_nxt = entry_lit(step_nxt);
            end
          end else begin
            if (step_r == PH_QP) cqp_nxt = {1'b1, acc_nxt[6:0]};
            step_nxt = uw.done;
            idx_nxt  = '0;
            acc_nxt  = '0;
            left_nxt = entry_lit(step_nxt);
          end
        end
      end else begin
        unique case (uw.kind)
          JK_ALWAYS, JK_BIT: begin
            if (uw.set_map) map_nxt = bit_val;
            step_nxt = (uw.kind == JK_BIT && bit_val) ? uw.jmp1 : uw.jmp0;
            if (uw.map_sel && !bit_val && map_r) step_nxt = PH_SEG_PROB;
            idx_nxt  = '0;
            acc_nxt  = '0;
            left_nxt = entry_lit(step_nxt);
          end
          JK_LOOP: begin
            if (bit_val) begin
              left_nxt = uw.lit;
              acc_nxt  = '0;
            end else begin
              idx_nxt = idx_r + 4'd1;
              if (idx_nxt >= uw.count) begin
                step_nxt = exit_ph(uw, map_r);
                idx_nxt  = '0;
                acc_nxt  = '0;
                left_nxt = entry_lit(step_nxt);
              end
            end
          end
          default: ;
        endcase
      end
    end
    if (clear) begin
      step_nxt = PH_CS;
      idx_nxt  = '0;
      left_nxt = '0;
      acc_nxt  = '0;
      map_nxt  = 1'b0;
      cqp_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= PH_CS;
      idx_r  <= '0;
      left_r <= '0;
      acc_r  <= '0;
      map_r  <= 1'b0;
      cqp_r  <= '0;
    end else begin
      step_r <= step_nxt;
      idx_r  <= idx_nxt;
      left_r <= left_nxt;
      acc_r  <= acc_nxt;
      map_r  <= map_nxt;
      cqp_r  <= cqp_nxt;
    end
  end

  assign qp_done = cqp_r[7];
  assign qp      = cqp_r[6:0];

  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    qp_done |-> (step_r == PH_DONE)) else $error("qp captured outside done phase");
  a_no_bits_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (qp_done && !clear && !start) |=> qp_done) else $error("qp capture lost");
  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= 4'd8) else $error("literal length out of range");

endmodule

FILE: verif/vp8hq_checker.sv
// Checker for the VP8 header quantizer extractor: predicts each frame's result
// from the accepted items and compares with the result channel. Uses vp8hq_pkg.
`timescale 1ns / 100ps
module vp8hq_checker
  import vp8hq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [6:0] out_qp,
  input  logic [1:0] out_status,
  output int         fail_count,
  output int         pending
);

  logic [6:0] qp_q[$];
  logic [1:0] status_q[$];

  logic [COUNT_BITS-1:0] byte_cnt;
  int unsigned tag, used, rng, val, nbits, step, flags, acc, qp_reg, lidx, lleft;

  function automatic int unsigned part_len();
    return (tag >> 5) & 32'h7FFFF;
  endfunction

  function automatic int unsigned head_len();
    return flags[1] ? 10 : 3;
  endfunction

  task automatic hdr_reset();
    byte_cnt = '0;
    tag = 0; used = 0; rng = 255; val = 0; nbits = 0; step = 0;
    flags = 0; acc = 0; qp_reg = 0; lidx = 0; lleft = 0;
  endtask

  task automatic go(input int unsigned ph);
    step = ph; lidx = 0; acc = 0;
    case (ph)
      PH_FILT_LEVEL: lleft = 6;
      PH_SHARP:      lleft = 3;
      PH_NPART:      lleft = 2;
      PH_QP:         lleft = 7;
      default:       lleft = 0;
    endcase
  endtask

  task automatic seg_exit();
    go(flags[0] ? PH_SEG_PROB : PH_FILT_TYPE);
  endtask

  task automatic next_elem();
    int unsigned cnt;
    case (step)
      PH_SEG_Q, PH_SEG_LF: cnt = SEGMENT_COUNT;
      PH_SEG_PROB:         cnt = SEGMENT_TREE_PROBS;
      PH_REF:              cnt = REF_DELTA_COUNT;
      default:             cnt = MODE_DELTA_COUNT;
    endcase
    lidx = (lidx + 1) & 32'hF;
    if (lidx < cnt) return;
    case (step)
      PH_SEG_Q:    go(PH_SEG_LF);
      PH_SEG_LF:   seg_exit();
      PH_SEG_PROB: go(PH_FILT_TYPE);
      PH_REF:      go(PH_MODE);
      default:     go(PH_NPART);
    endcase
  endtask

  task automatic walk_bit(input int unsigned b);
    if (lleft > 0) begin
      acc = ((acc << 1) | b) & 32'hFF;
      lleft--;
      if (lleft > 0) return;
      case (step)
        PH_FILT_LEVEL: go(PH_SHARP);
        PH_SHARP:      go(PH_ADJ_EN);
        PH_NPART:      go(PH_QP);
        PH_QP: begin
          qp_reg = 32'h80 | (acc & 32'h7F);
          go(PH_DONE);
        end
        default: next_elem();
      endcase
      return;
    end
    case (step)
      PH_CS:     go(PH_CLAMP);
      PH_CLAMP:  go(PH_SEG_EN);
      PH_SEG_EN: go(b ? PH_SEG_MAP : PH_FILT_TYPE);
      PH_SEG_MAP: begin
        flags = (flags & ~32'h1) | b;
        go(PH_SEG_DATA);
      end
      PH_SEG_DATA: begin
        if (b) go(PH_SEG_MODE);
        else seg_exit();
      end
      PH_SEG_MODE: go(PH_SEG_Q);
      PH_SEG_Q, PH_SEG_LF, PH_SEG_PROB, PH_REF, PH_MODE: begin
        if (b) begin
          lleft = (step == PH_SEG_Q || step == PH_SEG_PROB) ? 8 : 7;
          acc = 0;
        end else begin
          next_elem();
        end
      end
      PH_FILT_TYPE: go(PH_FILT_LEVEL);
      PH_ADJ_EN:    go(b ? PH_ADJ_UPD : PH_NPART);
      PH_ADJ_UPD:   go(b ? PH_REF : PH_NPART);
      default: ;
    endcase
  endtask

  task automatic bool_decode();
    int unsigned split, b;
    forever begin
      if (nbits >= 8) begin
        if (used < part_len()) return;
        nbits = 0;
      end
      if (rng < 128) begin
        val = (val << 1) & 32'hFFFF;
        rng = (rng << 1) & 32'hFF;
        nbits++;
        continue;
      end
      if (qp_reg & 32'h80) return;
      split = 1 + (((rng - 1) * 128) >> 8);
      if (val >= (split << 8)) begin
        b = 1;
        rng -= split;
        val -= split << 8;
      end else begin
        b = 0;
        rng = split;
      end
      walk_bit(b);
    end
  endtask

  task automatic feed_byte(input int unsigned idx, input int unsigned b);
    int unsigned hd, plen;
    if (idx < 3) begin
      tag |= b << (8 * idx);
      if (idx == 2 && !tag[0]) flags |= 2;
      return;
    end
    hd = head_len();
    plen = part_len();
    if (idx < hd || plen < 2 || idx - hd >= plen) return;
    if (used < 2) begin
      val = ((val << 8) | b) & 32'hFFFF;
      used++;
      if (used == 2) begin
        go(flags[1] ? PH_CS : PH_SEG_EN);
        bool_decode();
      end
      return;
    end
    if (nbits >= 8) begin
      val = (val | b) & 32'hFFFF;
      nbits = 0;
      used++;
      bool_decode();
    end
  endtask

  task automatic frame_item(input logic [7:0] b, input logic last);
    int unsigned n;
    logic [1:0] st;
    logic [6:0] q;
    if (byte_cnt != COUNT_MAX) begin
      byte_cnt = byte_cnt + 1'b1;
      feed_byte(byte_cnt - 1, b);
    end
    if (!last) return;
    n = byte_cnt;
    q = '0;
    if (n < 3) st = 2'd1;
    else if (head_len() + part_len() > n) st = 2'd2;
    else if (!qp_reg[7] || used >= part_len()) st = 2'd3;
    else begin
      st = 2'd0;
      q = qp_reg[6:0];
    end
    qp_q.push_back(q);
    status_q.push_back(st);
    hdr_reset();
  endtask

  assign pending = qp_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      hdr_reset();
      qp_q.delete();
      status_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (qp_q.size() == 0) begin
          $display("%0t: result with none expected: qp %0d status %0d",
                   $time, out_qp, out_status);
          fail_count <= fail_count + 1;
        end else begin
          if (out_qp !== qp_q[0] || out_status !== status_q[0]) begin
            $display("%0t: mismatch: expected qp %0d status %0d, got qp %0d status %0d",
                     $time, qp_q[0], status_q[0], out_qp, out_status);
            fail_count <= fail_count + 1;
          end
          void'(qp_q.pop_front());
          void'(status_q.pop_front());
        end
      end
      if (in_valid && in_ready) frame_item(in_data_byte, in_last_byte);
    end
  end

endmodule

FILE: verif/testbench.sv
// Testbench top for the VP8 header quantizer extractor: drives frames and noise
// with random idling and receiver stalls; instantiates the block and vp8hq_checker; gives the verdict.
`timescale 1ns / 100ps
module testbench;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_ready;
  logic [6:0] out_qp;
  logic [1:0] out_status;
  int         fail_count;
  int         pending;
  int         send_idle;
  int         recv_stall;
  int         quiet_cycles;
  int         item_total;

  vp8_header_qp_extractor dut (.*);

  vp8hq_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 50000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    item_total++;
  endtask

  // fill: 0 random, 1 zeros, 2 ones
  task automatic send_frame(input bit key, input int unsigned plen, input int extra,
                            input int fill);
    logic [23:0] tag;
    int total, i;
    logic [7:0] b;
    tag = {plen[18:0], 4'($urandom), ~key};
    total = 3 + (key ? 7 : 0) + int'(plen) + extra;
    if (total < 1) total = 1;
    for (i = 0; i < total; i++) begin
      if (i < 3) b = tag[8*i +: 8];
      else if (fill == 1) b = 8'h00;
      else if (fill == 2) b = 8'hFF;
      else b = 8'($urandom);
      send_item(b, i == total - 1);
    end
  endtask

  task automatic send_noise();
    int len, i;
    len = $urandom_range(1, 20);
    for (i = 0; i < len; i++) send_item(8'($urandom), i == len - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int ph, target, r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    item_total = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
    send_frame(1'b1, 0, 0, 0);
    send_frame(1'b0, 1, 0, 0);
    send_frame(1'b1, 1, 2, 0);
    send_frame(1'b1, 20, -1, 0);
    send_frame(1'b0, 20, -5, 0);
    send_frame(1'b1, 2, 0, 0);
    send_frame(1'b1, 30, 3, 1);
    send_frame(1'b0, 30, 0, 2);
    send_frame(1'b1, 24, 0, 0);
    send_frame(1'b0, 24, 4, 0);
    send_frame(1'b0, 19'h7FFFF, -((1 << 19) + 2), 0);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? (ph == 1 ? 49 : 32) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 49 : 32) : 0;
      target = item_total + 425;
      while (item_total < target) begin
        r = $urandom_range(99);
        if (r < 10) send_noise();
        else if (r < 15) send_frame($urandom_range(1), $urandom_range(1), $urandom_range(3), 0);
        else if (r < 22) send_frame($urandom_range(1), $urandom_range(2, 40),
                                    -int'($urandom_range(1, 6)), 0);
        else if (r < 25) send_frame($urandom_range(1), $urandom_range(60, 200), 0, 0);
        else send_frame($urandom_range(1), $urandom_range(2, 30), $urandom_range(3), 0);
        if (r == 50) drain();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
